[rtl/ale_pkg.sv]
`default_nettype none
package ale_pkg;

    localparam int CAPACITY = 128;

    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 8;
    localparam int TOTAL_W  = 39;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ASC    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DESC   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    localparam logic [2:0] MODE_HOLD    = 3'd0;
    localparam logic [2:0] MODE_ROTATE  = 3'd1;
    localparam logic [2:0] MODE_SORT    = 3'd2;
    localparam logic [2:0] MODE_LOAD    = 3'd3;
    localparam logic [2:0] MODE_COMPACT = 3'd4;

    typedef struct packed {
        logic [2:0]        mode;
        logic              phase;
        logic              desc;
        logic [WORD_W-1:0] load_word;
    } t_ctl;

endpackage
`default_nettype wire

[rtl/ale_cell.sv]
`default_nettype none
module ale_cell
    import ale_pkg::*;
#(
    parameter int CAP = CAPACITY,
    parameter int IDX = 0
) (
    input  wire                          i_clk,
    input  t_ctl                         i_ctl,
    input  wire  [$clog2(CAP+1)-1:0]     i_count,
    input  wire  [$clog2(CAP)-1:0]       i_kpos,
    input  wire  [WORD_W-1:0]            i_left_word,
    input  wire                          i_left_swap,
    input  wire  [WORD_W-1:0]            i_right_word,
    output logic [WORD_W-1:0]            o_word,
    output logic                         o_swap_r
);

    localparam int CW = $clog2(CAP+1);
    localparam int IW = $clog2(CAP);
    localparam logic PAR = (IDX % 2) != 0;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              pair_on;
    logic              gt;
    logic              lt;

    assign pair_on  = (i_ctl.phase == PAR) && (CW'(IDX + 1) < i_count);
    assign gt       = $signed(r_word) > $signed(i_right_word);
    assign lt       = $signed(r_word) < $signed(i_right_word);
    assign o_swap_r = pair_on && (i_ctl.desc ? lt : gt);
    assign o_word   = r_word;

    always_comb begin
        case (i_ctl.mode)
            MODE_ROTATE:  n_word = i_right_word;
            MODE_SORT:    n_word = o_swap_r ? i_right_word :
                                   (i_left_swap ? i_left_word : r_word);
            MODE_LOAD:    n_word = (CW'(IDX) == i_count) ? i_ctl.load_word : r_word;
            MODE_COMPACT: n_word = (IW'(IDX) >= i_kpos) ? i_right_word : r_word;
            default:      n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule
`default_nettype wire

[rtl/ale_stats.sv]
`default_nettype none
module ale_stats
    import ale_pkg::*;
#(
    parameter int CAP = CAPACITY
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_clear,
    input  wire                              i_take,
    input  wire  [WORD_W-1:0]                i_word,
    output logic [WORD_W+$clog2(CAP):0]      o_sum,
    output logic [$clog2(CAP)-1:0]           o_imax,
    output logic [$clog2(CAP)-1:0]           o_imin
);

    localparam int IW = $clog2(CAP);
    localparam int SW = WORD_W + IW + 1;

    logic [IW-1:0]     r_pos;
    logic              r_any;
    logic [WORD_W-1:0] r_max;
    logic [WORD_W-1:0] r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos  <= '0;
            r_any  <= 1'b0;
            o_sum  <= '0;
            o_imax <= '0;
            o_imin <= '0;
        end else if (i_take) begin
            r_pos <= r_pos + 1'b1;
            r_any <= 1'b1;
            o_sum <= o_sum + SW'($signed(i_word));
            if (!r_any || $signed(i_word) > $signed(r_max)) begin
                r_max  <= i_word;
                o_imax <= r_pos;
            end
            if (!r_any || $signed(i_word) < $signed(r_min)) begin
                r_min  <= i_word;
                o_imin <= r_pos;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/array_list_engine.sv]
// channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------------
// input    | i_valid  | o_stall  | i_action, i_value, i_index
// output   | o_valid  | i_stall  | o_ok, o_count, o_is_empty, o_max_index,
//          |          |          | o_min_index, o_total, o_read_value
// From accept to result: reads, unknown codes, refused appends and unmatched
// removes take the rotation pass through the cell chain; appends first load
// the new word, matched removes compact after the pass, and sorts run the
// transposition phases before the pass.
// Reset clears the count and control; words need no reset.
// A result waits in the output register while the next transaction is taken.
`default_nettype none
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAP = CAPACITY
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [ACTION_W-1:0]    i_action,
    input  wire  [WORD_W-1:0]      i_value,
    input  wire  [INDEX_W-1:0]     i_index,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic                   o_ok,
    output logic [COUNT_W-1:0]     o_count,
    output logic                   o_is_empty,
    output logic [INDEX_W-1:0]     o_max_index,
    output logic [INDEX_W-1:0]     o_min_index,
    output logic [TOTAL_W-1:0]     o_total,
    output logic [WORD_W-1:0]      o_read_value
);

    localparam int CW = $clog2(CAP+1);
    localparam int IW = $clog2(CAP);
    localparam int SW = WORD_W + IW + 1;
    localparam int XW = CW + INDEX_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOAD    = 3'd1;
    localparam logic [2:0] S_SORT    = 3'd2;
    localparam logic [2:0] S_PASS    = 3'd3;
    localparam logic [2:0] S_COMPACT = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_count;
    logic [ACTION_W-1:0] r_act;
    logic [WORD_W-1:0]   r_value;
    logic [INDEX_W-1:0]  r_index;
    logic [IW-1:0]       r_step;
    logic                r_phase;
    logic                r_found;
    logic [IW-1:0]       r_kpos;
    logic                r_ok;
    logic [WORD_W-1:0]   r_rd;

    t_ctl                ctl;
    logic [WORD_W-1:0]   w_word [CAP];
    logic                w_swap [CAP];
    logic [WORD_W-1:0]   head;
    logic                accept;
    logic                in_list;
    logic                match;
    logic                take;
    logic                last;
    logic [SW-1:0]       sum;
    logic [IW-1:0]       imax;
    logic [IW-1:0]       imin;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign head    = w_word[0];
    assign last    = (r_step == IW'(CAP - 1));
    assign in_list = (r_state == S_PASS) && (CW'(r_step) < r_count);
    assign match   = in_list && (r_act == ACT_REMOVE) && !r_found && (head == r_value);
    assign take    = in_list && !match;

    always_comb begin
        ctl.phase     = r_phase;
        ctl.desc      = (r_act == ACT_DESC);
        ctl.load_word = r_value;
        case (r_state)
            S_LOAD:    ctl.mode = MODE_LOAD;
            S_SORT:    ctl.mode = MODE_SORT;
            S_PASS:    ctl.mode = MODE_ROTATE;
            S_COMPACT: ctl.mode = MODE_COMPACT;
            default:   ctl.mode = MODE_HOLD;
        endcase
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        ale_cell #(.CAP(CAP), .IDX(g)) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_kpos       (r_kpos),
            .i_left_word  ((g == 0) ? '0 : w_word[(g == 0) ? 0 : g-1]),
            .i_left_swap  ((g == 0) ? 1'b0 : w_swap[(g == 0) ? 0 : g-1]),
            .i_right_word (w_word[(g == CAP-1) ? 0 : g+1]),
            .o_word       (w_word[g]),
            .o_swap_r     (w_swap[g])
        );
    end

    ale_stats #(.CAP(CAP)) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept),
        .i_take  (take),
        .i_word  (head),
        .o_sum   (sum),
        .o_imax  (imax),
        .o_imin  (imin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_phase <= 1'b0;
            r_found <= 1'b0;
            r_ok    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act   <= i_action;
                        r_value <= i_value;
                        r_index <= i_index;
                        r_step  <= '0;
                        r_phase <= 1'b0;
                        r_found <= 1'b0;
                        r_kpos  <= '0;
                        r_rd    <= '0;
                        case (i_action)
                            ACT_APPEND: begin
                                r_ok    <= (r_count < CW'(CAP));
                                r_state <= (r_count < CW'(CAP)) ? S_LOAD : S_PASS;
                            end
                            ACT_ASC, ACT_DESC: begin
                                r_ok    <= 1'b1;
                                r_state <= S_SORT;
                            end
                            ACT_READ: begin
                                r_ok    <= (XW'(i_index) < XW'(r_count));
                                r_state <= S_PASS;
                            end
                            default: begin
                                r_ok    <= 1'b0;
                                r_state <= S_PASS;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_PASS;
                end
                S_SORT: begin
                    r_phase <= !r_phase;
                    r_step  <= last ? '0 : r_step + 1'b1;
                    if (last) begin
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_step <= r_step + 1'b1;
                    if (match) begin
                        r_found <= 1'b1;
                        r_kpos  <= r_step;
                        r_ok    <= 1'b1;
                    end
                    if (in_list && (r_act == ACT_READ) &&
                        ((XW'(r_index)) == (XW'(r_step)))) begin
                        r_rd <= head;
                    end
                    if (last) begin
                        r_state <= (r_found || match) ? S_COMPACT : S_DONE;
                    end
                end
                S_COMPACT: begin
                    r_count <= r_count - 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!o_valid || !i_stall)) begin
            o_ok         <= r_ok;
            o_count      <= COUNT_W'(r_count);
            o_is_empty   <= (r_count == '0);
            o_max_index  <= INDEX_W'(imax);
            o_min_index  <= INDEX_W'(imin);
            o_total      <= TOTAL_W'(sum);
            o_read_value <= r_rd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("count beyond capacity");
    a_load_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> r_count == $past(r_count) + 1'b1)
        else $error("append did not grow the list");
    a_found_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS && r_found) |-> r_act == ACT_REMOVE)
        else $error("match flagged outside remove");
    a_compact_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPACT |-> r_found && r_count != '0)
        else $error("compaction without a match");
`endif

endmodule
`default_nettype wire
